// ===== rtl/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, constants, the stage record and round helpers of the
// 64-bit four-word block cipher.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int ROUNDS   = 16;
   localparam int WORD_W   = 16;
   localparam int BLOCK_W  = 4 * WORD_W;
   localparam int KEY_W    = 64;
   localparam int ROT_MIX  = 3;
   localparam int ROT_W1   = 5;
   localparam int KEY_STEP = 2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [KEY_W-1:0]   key_type;

   typedef struct packed {
      logic      valid;
      logic      op;
      block_type block;
   } stage_type;

   function automatic word_type rotl16(input word_type x, input int unsigned s);
      logic [2*WORD_W-1:0] xx;
      xx = {x, x} << (s % WORD_W);
      return xx[2*WORD_W-1:WORD_W];
   endfunction

   function automatic word_type round_subkey(input key_type key, input int unsigned r);
      logic [2*KEY_W-1:0] kk;
      kk = {key, key};
      return kk[(KEY_STEP * r) % KEY_W +: WORD_W];
   endfunction

endpackage

// ===== rtl/fbc_if.sv =====
// ----------------------------------------------------------------------------
// fbc_req_if / fbc_rsp_if
// Valid/ready channels for cipher requests and cipher responses.
// ----------------------------------------------------------------------------
interface fbc_req_if import fbc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      op;
   block_type block_in;

   modport source (output valid, output op, output block_in, input ready);
   modport sink   (input valid, input op, input block_in, output ready);
endinterface

interface fbc_rsp_if import fbc_pkg::*; ();
   logic      valid;
   logic      ready;
   block_type block_out;

   modport source (output valid, output block_out, input ready);
   modport sink   (input valid, input block_out, output ready);
endinterface

// ===== rtl/fbc_cell.sv =====
// ----------------------------------------------------------------------------
// fbc_cell
// One round of the cipher: applies the encrypt or decrypt round to the
// incoming stage and registers it for the next cell.
// ----------------------------------------------------------------------------
module fbc_cell import fbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  word_type  rk_enc,
   input  word_type  rk_dec,
   input  stage_type stage_in,
   output stage_type stage_out
);

   logic      valid_ff;
   logic      op_ff;
   block_type block_ff;
   block_type block_in;
   word_type  w0, w1, w2, w3;
   word_type  e0, e1, e2, e3;
   word_type  d0, d1, d2, d3;

   always_comb begin
      w0 = stage_in.block[0*WORD_W +: WORD_W];
      w1 = stage_in.block[1*WORD_W +: WORD_W];
      w2 = stage_in.block[2*WORD_W +: WORD_W];
      w3 = stage_in.block[3*WORD_W +: WORD_W];

      e3 = rotl16(w1, ROT_W1);
      e1 = e3 ^ w3;
      e2 = e1 ^ w0;
      e0 = rotl16(w0, ROT_MIX) ^ ~rk_enc ^ w2;

      d1 = rotl16(w3, WORD_W - ROT_W1);
      d3 = w1 ^ w3;
      d0 = w1 ^ w2;
      d2 = rotl16(d0, ROT_MIX) ^ ~rk_dec ^ w0;

      if (stage_in.op == OP_DECRYPT) begin
         block_in = {d3, d2, d1, d0};
      end else begin
         block_in = {e3, e2, e1, e0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff    <= stage_in.op;
         block_ff <= block_in;
      end
   end

   assign stage_out = '{valid: valid_ff, op: op_ff, block: block_ff};

endmodule

// ===== rtl/feistel_block_cipher_64.sv =====
// ----------------------------------------------------------------------------
// feistel_block_cipher_64
// 64-bit four-word block cipher, one round per cell in a chain of cells.
// ----------------------------------------------------------------------------
// A block enters the chain on every cycle that the request channel transfers
// and crosses ROUNDS (16) cells, one block per cycle unless the chain stalls.
// Each cell performs one round, encrypt or decrypt as the block's op bit
// selects, so blocks of both directions mix freely. When a response waits
// untaken the whole chain holds and the request channel stalls. Write the key
// only while no block is in flight; it takes effect in the next cycle.
module feistel_block_cipher_64 import fbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   fbc_req_if.sink          req_chan,
   fbc_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  key_type          csr_wr_data
);

   key_type   csr_key_ff;
   logic      advance;
   stage_type stage [0:ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_key_ff <= '0;
      end else if (csr_wr_en) begin
         csr_key_ff <= csr_wr_data;
      end
   end

   assign advance        = !stage[ROUNDS].valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign stage[0]       = '{valid: req_chan.valid, op: req_chan.op, block: req_chan.block_in};

   for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
      fbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .rk_enc    (round_subkey(csr_key_ff, i)),
         .rk_dec    (round_subkey(csr_key_ff, ROUNDS - 1 - i)),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   assign rsp_chan.valid     = stage[ROUNDS].valid;
   assign rsp_chan.block_out = stage[ROUNDS].block;

`ifndef SYNTH
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while response stalled");

   a_first_cell_loads: assert property (@(posedge clock) disable iff (reset)
      !reset && advance |=> stage[1].valid == $past(req_chan.valid))
      else $error("first cell lost or invented a transfer");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !reset && !advance |=> $stable(stage[ROUNDS].block))
      else $error("result changed during stall");
`endif

endmodule
